// ===== src/cdoa_pkg.sv =====
// ----------------------------------------------------------------------------
// cdoa_pkg
// Shared types, constants and calendar helpers for the date offset adder.
// ----------------------------------------------------------------------------
package cdoa_pkg;

  // port field widths
  localparam int YearW  = 16;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int AddMW  = 8;
  localparam int AddDW  = 8;

  // internal widths
  localparam int YearIntW = 18;  // sum of two 16-bit years plus month carries
  localparam int MonIntW  = 9;   // -128 .. 142 before normalization
  localparam int DayIntW  = 9;   // -128 .. 158
  localparam int ResW     = 9;   // year residue modulo 400
  localparam int MnormW   = 10;  // biased month index 3 .. 273
  localparam int MprodW   = 16;
  localparam int ModVW    = 18;  // biased year 53 .. 131145
  localparam int ModProdW = 37;
  localparam int ModQW    = 10;

  localparam int MonthsPerYear = 12;

  // month normalization: (m - 1 + 132) / 12 by reciprocal 171 / 2^11
  localparam logic signed [MnormW-1:0] MonBias  = 10'sd131;
  localparam logic [MprodW-1:0]        MonRecip = 16'd171;
  localparam int                       MonShift = 11;
  localparam logic signed [YearIntW-1:0] MonQOffset = 18'sd11;

  // year residue: (y + 400 * 164) / 400 by reciprocal ceil(2^27 / 400)
  localparam logic [ModVW-1:0]    ModBias  = 18'd65600;
  localparam logic [ModProdW-1:0] ModRecip = 37'd335545;
  localparam int                  ModShift = 27;
  localparam logic [ModVW:0]      YearCycle = 19'd400;
  localparam logic [ResW-1:0]     ResLast   = 9'd399;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MONTH,
    ST_MUL,
    ST_MOD,
    ST_DAY,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic month_norm;
    logic mod_mul;
    logic mod_fix;
    logic day_step;
    logic out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic day_done;
  } dp_stat_t;

  // leap test on the year residue modulo 400
  function automatic logic leap_of(input logic [ResW-1:0] r);
    logic by4;
    logic century;
    by4     = (r[1:0] == 2'b00);
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return by4 && !century;
  endfunction

  // days in month m (1..12)
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/cdoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdoa_ctrl
// Sequencer for the date offset adder: input/output handshake and datapath
// command generation.
// ----------------------------------------------------------------------------
module cdoa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cdoa_pkg::dp_cmd_t  cmd_o,
  input  cdoa_pkg::dp_stat_t stat_i
);
  import cdoa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // result slot can take a new item when empty or being drained
  assign slot_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MONTH;
      ST_MONTH: state_d = ST_MUL;
      ST_MUL:   state_d = ST_MOD;
      ST_MOD:   state_d = ST_DAY;
      ST_DAY:   if (stat_i.day_done) state_d = ST_DONE;
      ST_DONE:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_MONTH: cmd_o.month_norm = 1'b1;
      ST_MUL:   cmd_o.mod_mul    = 1'b1;
      ST_MOD:   cmd_o.mod_fix    = 1'b1;
      ST_DAY:   cmd_o.day_step   = !stat_i.day_done;
      ST_DONE:  cmd_o.out_load   = slot_free;
      default:  cmd_o            = '0;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/cdoa_dpath.sv =====
// ----------------------------------------------------------------------------
// cdoa_dpath
// Datapath for the date offset adder: field sums, month normalization,
// year residue modulo 400, one-month day steps and the result register.
// ----------------------------------------------------------------------------
module cdoa_dpath (
  input  logic                                clk_i,
  input  cdoa_pkg::dp_cmd_t                   cmd_i,
  output cdoa_pkg::dp_stat_t                  stat_o,
  input  logic signed [cdoa_pkg::YearW-1:0]   base_year_i,
  input  logic        [cdoa_pkg::MonthW-1:0]  base_month_i,
  input  logic        [cdoa_pkg::DayW-1:0]    base_day_i,
  input  logic signed [cdoa_pkg::YearW-1:0]   add_year_i,
  input  logic signed [cdoa_pkg::AddMW-1:0]   add_month_i,
  input  logic signed [cdoa_pkg::AddDW-1:0]   add_day_i,
  output logic signed [cdoa_pkg::YearW-1:0]   out_year_o,
  output logic        [cdoa_pkg::MonthW-1:0]  out_month_o,
  output logic        [cdoa_pkg::DayW-1:0]    out_day_o,
  output logic                                year_overflow_o
);
  import cdoa_pkg::*;

  logic signed [YearIntW-1:0] year_q, year_d;
  logic signed [MonIntW-1:0]  mon_q, mon_d;
  logic signed [DayIntW-1:0]  day_q, day_d;
  logic        [ResW-1:0]     res_q, res_d;
  logic        [ModVW-1:0]    modv_q;
  logic        [ModProdW-1:0] prod_q;

  logic signed [YearW-1:0]    oyear_q;
  logic        [MonthW-1:0]   omon_q;
  logic        [DayW-1:0]     oday_q;
  logic                       oovf_q;

  // month normalization
  logic signed [MnormW-1:0] mbias_s;
  logic        [MnormW-1:0] mbias;
  logic        [MprodW-1:0] mprod;
  logic        [4:0]        mquo;
  logic        [MnormW-1:0] mrem;
  logic        [MonthW-1:0] mon_norm;
  logic signed [YearIntW-1:0] year_norm;

  assign mbias_s  = MnormW'(mon_q) + MonBias;
  assign mbias    = $unsigned(mbias_s);
  assign mprod    = MprodW'(mbias) * MonRecip;
  assign mquo     = mprod[MprodW-1:MonShift];
  assign mrem     = mbias - (MnormW'(mquo) * 10'd12);
  assign mon_norm = mrem[MonthW-1:0] + 4'd1;
  assign year_norm = year_q + $signed(YearIntW'(mquo)) - MonQOffset;

  // year residue modulo 400
  logic [ModVW-1:0] modv;
  logic [ModQW-1:0] modq;
  logic [ModVW:0]   mod_rem0;
  logic [ModVW:0]   mod_rem;

  assign modv     = $unsigned(year_q) + ModBias;
  assign modq     = prod_q[ModProdW-1:ModShift];
  assign mod_rem0 = {1'b0, modv_q} - ((ModVW+1)'(modq) * YearCycle);
  assign mod_rem  = (mod_rem0 >= YearCycle) ? (mod_rem0 - YearCycle) : mod_rem0;

  // neighbor months for one day step
  logic [MonthW-1:0]   mon_cur, mon_next, mon_prev;
  logic [ResW-1:0]     res_next, res_prev;
  logic [YearIntW-1:0] year_next, year_prev;
  logic [DayW-1:0]     len_cur, len_prev;
  logic                go_fwd, go_back;

  always_comb begin
    mon_cur   = mon_q[MonthW-1:0];
    mon_next  = mon_cur + 4'd1;
    res_next  = res_q;
    year_next = $unsigned(year_q);
    if (mon_cur == 4'(MonthsPerYear)) begin
      mon_next  = 4'd1;
      res_next  = (res_q == ResLast) ? '0 : res_q + 9'd1;
      year_next = $unsigned(year_q) + 18'd1;
    end
    mon_prev  = mon_cur - 4'd1;
    res_prev  = res_q;
    year_prev = $unsigned(year_q);
    if (mon_cur == 4'd1) begin
      mon_prev  = 4'(MonthsPerYear);
      res_prev  = (res_q == '0) ? ResLast : res_q - 9'd1;
      year_prev = $unsigned(year_q) - 18'd1;
    end
  end

  assign len_cur  = month_len(mon_cur, leap_of(res_q));
  assign len_prev = month_len(mon_prev, leap_of(res_prev));
  assign go_fwd   = day_q > $signed(DayIntW'(len_cur));
  assign go_back  = day_q < $signed(9'sd1);
  assign stat_o.day_done = !go_fwd && !go_back;

  // next working values
  always_comb begin
    year_d = year_q;
    mon_d  = mon_q;
    day_d  = day_q;
    res_d  = res_q;
    if (cmd_i.load) begin
      year_d = YearIntW'(base_year_i) + YearIntW'(add_year_i);
      mon_d  = $signed(MonIntW'(base_month_i)) + MonIntW'(add_month_i);
      day_d  = $signed(DayIntW'(base_day_i)) + DayIntW'(add_day_i);
    end else if (cmd_i.month_norm) begin
      year_d = year_norm;
      mon_d  = $signed(MonIntW'(mon_norm));
    end else if (cmd_i.mod_fix) begin
      res_d = mod_rem[ResW-1:0];
    end else if (cmd_i.day_step) begin
      if (go_fwd) begin
        day_d  = day_q - $signed(DayIntW'(len_cur));
        mon_d  = $signed(MonIntW'(mon_next));
        year_d = $signed(year_next);
        res_d  = res_next;
      end else begin
        day_d  = day_q + $signed(DayIntW'(len_prev));
        mon_d  = $signed(MonIntW'(mon_prev));
        year_d = $signed(year_prev);
        res_d  = res_prev;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    year_q <= year_d;
    mon_q  <= mon_d;
    day_q  <= day_d;
    res_q  <= res_d;
    if (cmd_i.mod_mul) begin
      modv_q <= modv;
      prod_q <= ModProdW'(modv) * ModRecip;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      oyear_q <= year_q[YearW-1:0];
      omon_q  <= mon_q[MonthW-1:0];
      oday_q  <= day_q[DayW-1:0];
      oovf_q  <= !((year_q[YearIntW-1:YearW-1] == '0) ||
                   (year_q[YearIntW-1:YearW-1] == '1));
    end
  end

  assign out_year_o      = oyear_q;
  assign out_month_o     = omon_q;
  assign out_day_o       = oday_q;
  assign year_overflow_o = oovf_q;

endmodule

// ===== src/calendar_date_offset_add_unit.sv =====
// ----------------------------------------------------------------------------
// calendar_date_offset_add_unit
// Adds signed year, month and day offsets to a Gregorian date and
// normalizes month and day, with a 16-bit year overflow flag.
//
//   channel  direction  handshake                fields
//   in       sink       in_valid_i / in_stall_o  base_*, add_*
//   out      source     out_valid_o / out_stall_i out_year/month/day, overflow
//
// After transfer, an item passes through the month normalization, residue
// multiply, residue fix and day loop states to the result load; the day loop
// makes k one-month day steps (at most 5 for the offset range). The next input
// transfer can follow in the cycle after the load.
// The day loop steps one month per cycle using the current and previous
// month length lookups.
// Reset is asynchronous and active low and clears the sequencer and the
// result valid flag. A held result does not block the next input transfer;
// that item then waits in its last state until the result slot drains.
// ----------------------------------------------------------------------------
module calendar_date_offset_add_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cdoa_pkg::YearW-1:0]   base_year_i,
  input  logic        [cdoa_pkg::MonthW-1:0]  base_month_i,
  input  logic        [cdoa_pkg::DayW-1:0]    base_day_i,
  input  logic signed [cdoa_pkg::YearW-1:0]   add_year_i,
  input  logic signed [cdoa_pkg::AddMW-1:0]   add_month_i,
  input  logic signed [cdoa_pkg::AddDW-1:0]   add_day_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cdoa_pkg::YearW-1:0]   out_year_o,
  output logic        [cdoa_pkg::MonthW-1:0]  out_month_o,
  output logic        [cdoa_pkg::DayW-1:0]    out_day_o,
  output logic                                year_overflow_o
);
  import cdoa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  cdoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // datapath
  cdoa_dpath u_dpath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .base_year_i     (base_year_i),
    .base_month_i    (base_month_i),
    .base_day_i      (base_day_i),
    .add_year_i      (add_year_i),
    .add_month_i     (add_month_i),
    .add_day_i       (add_day_i),
    .out_year_o      (out_year_o),
    .out_month_o     (out_month_o),
    .out_day_o       (out_day_o),
    .year_overflow_o (year_overflow_o)
  );

endmodule
